/* rtl/lsrd_pkg.sv */
// ----------------------------------------------------------------------------
// lsrd_pkg
// Shared constants, codes and control types of the laser scan reply decoder.
// ----------------------------------------------------------------------------
package lsrd_pkg;

  localparam int LINE_DATA_CHARS = 64;
  localparam int READING_LIMIT   = 1024;
  localparam int STORE_DEPTH     = LINE_DATA_CHARS + 2;
  localparam int LEN_W           = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W          = $clog2(STORE_DEPTH);
  localparam int RCNT_W          = $clog2(READING_LIMIT + 1);

  localparam logic [7:0]  CHAR_BASE   = 8'h30;
  localparam logic [7:0]  CHAR_LF     = 8'h0A;
  localparam logic [19:0] STAMP_SCALE = 20'd1000000;

  localparam logic [1:0] ACT_BYTE      = 2'd0;
  localparam logic [1:0] ACT_START     = 2'd1;
  localparam logic [1:0] ACT_CLK_RESET = 2'd2;

  localparam logic [1:0] KIND_STAMP   = 2'd0;
  localparam logic [1:0] KIND_READING = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_STAMP_SUM = 3'd1;
  localparam logic [2:0] ERR_REPEAT    = 3'd2;
  localparam logic [2:0] ERR_DATA_SUM  = 3'd3;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd5;

  typedef enum logic [1:0] {
    PH_STAMP,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_STAMP_OUT,
    ST_ERR_OUT,
    ST_END_OUT,
    ST_W_CHECK,
    ST_W_FETCH,
    ST_W_TAKE,
    ST_W_EMIT,
    ST_C_CHECK,
    ST_C_FETCH,
    ST_C_WRITE
  } ctl_state_t;

  typedef struct packed {
    logic       store_byte;
    logic       start_scan;
    logic       clock_reset;
    logic       set_err;
    logic [2:0] err_code;
    logic       repeat_bump;
    logic       stamp_commit;
    logic       mul_lo;
    logic       mul_hi;
    logic       load_stamp;
    logic       load_err;
    logic       load_end;
    logic       walk_start;
    logic       read_begin;
    logic       read_take;
    logic       load_reading;
    logic       copy_write;
    logic       copy_finish;
  } dp_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   is_lf;
    logic   full;
    logic   stamp_ok;
    logic   repeat_fail;
    logic   line_empty;
    logic   data_sum_ok;
    logic   reading_fits;
    logic   limit_hit;
    logic   take_last;
    logic   copy_done;
    logic   out_free;
  } dp_status_t;

endpackage

/* rtl/lsrd_ctrl.sv */
// ----------------------------------------------------------------------------
// lsrd_ctrl
// Sequencer: takes one transaction at a time and steps the datapath through
// timestamp scaling, reading extraction and carry copy.
// ----------------------------------------------------------------------------
module lsrd_ctrl import lsrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  input  dp_status_t status,
  output logic       in_stall,
  output dp_cmd_t    cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_START:     cmd.start_scan = 1'b1;
            ACT_CLK_RESET: cmd.clock_reset = 1'b1;
            ACT_BYTE: begin
              if (status.phase != PH_HALT) begin
                if (!status.is_lf) begin
                  if (status.full) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ERR_OVERFLOW;
                    state_next   = ST_ERR_OUT;
                  end else begin
                    cmd.store_byte = 1'b1;
                  end
                end else if (status.phase == PH_STAMP) begin
                  if (!status.stamp_ok) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ERR_STAMP_SUM;
                    state_next   = ST_ERR_OUT;
                  end else if (status.repeat_fail) begin
                    cmd.repeat_bump = 1'b1;
                    cmd.set_err     = 1'b1;
                    cmd.err_code    = ERR_REPEAT;
                    state_next      = ST_ERR_OUT;
                  end else begin
                    cmd.stamp_commit = 1'b1;
                    state_next       = ST_MUL_LO;
                  end
                end else begin
                  if (status.line_empty) begin
                    state_next = ST_END_OUT;
                  end else if (!status.data_sum_ok) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ERR_DATA_SUM;
                    state_next   = ST_ERR_OUT;
                  end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_W_CHECK;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_STAMP_OUT;
      end
      ST_STAMP_OUT: begin
        if (status.out_free) begin
          cmd.load_stamp = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_ERR_OUT: begin
        if (status.out_free) begin
          cmd.load_err = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_END_OUT: begin
        if (status.out_free) begin
          cmd.load_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_W_CHECK: begin
        if (!status.reading_fits) begin
          state_next = ST_C_CHECK;
        end else if (status.limit_hit) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ERR_TOO_MANY;
          state_next   = ST_ERR_OUT;
        end else begin
          cmd.read_begin = 1'b1;
          state_next     = ST_W_FETCH;
        end
      end
      ST_W_FETCH: state_next = ST_W_TAKE;
      ST_W_TAKE: begin
        cmd.read_take = 1'b1;
        state_next    = status.take_last ? ST_W_EMIT : ST_W_FETCH;
      end
      ST_W_EMIT: begin
        if (status.out_free) begin
          cmd.load_reading = 1'b1;
          state_next       = ST_W_CHECK;
        end
      end
      ST_C_CHECK: begin
        if (status.copy_done) begin
          cmd.copy_finish = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_C_FETCH;
        end
      end
      ST_C_FETCH: state_next = ST_C_WRITE;
      ST_C_WRITE: begin
        cmd.copy_write = 1'b1;
        state_next     = ST_C_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/lsrd_dp.sv */
// ----------------------------------------------------------------------------
// lsrd_dp
// Datapath: line memory, running sums, time extension, scaling multiplier,
// reading assembly and the output register.
// ----------------------------------------------------------------------------
module lsrd_dp import lsrd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic [7:0]   rx_byte,
  input  dp_cmd_t      cmd,
  output dp_status_t   status,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [1:0]   kind,
  output logic [63:0]  stamp_ns,
  output logic [17:0]  range_mm,
  output logic [17:0]  strength,
  output logic [2:0]   error_code,
  output logic         last
);

  logic [7:0]        line_mem [STORE_DEPTH];
  logic [7:0]        rd_data;
  logic              with_intensity;
  phase_t            phase;
  logic [LEN_W-1:0]  line_length;
  logic [2:0]        carry_count;
  logic [RCNT_W-1:0] reading_count;
  logic [5:0]        line_sum;
  logic [7:0]        last_byte;
  logic [29:0]       six_shift;
  logic [23:0]       prev_time;
  logic [31:0]       wrap_count;
  logic [1:0]        repeat_count;
  logic [2:0]        err_r;
  logic [47:0]       prod_lo;
  logic [35:0]       prod_hi;
  logic [LEN_W-1:0]  rd_ptr;
  logic [2:0]        cp_dst;
  logic [2:0]        g_cnt;
  logic [35:0]       gather;

  logic [5:0]        rx_six;
  logic [5:0]        rd_six;
  logic [7:0]        sum_char;
  logic [23:0]       t_now;
  logic [55:0]       ext_time;
  logic [2:0]        size;
  logic [LEN_W-1:0]  usable;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              out_free;

  assign rx_six   = 6'(rx_byte - CHAR_BASE);
  assign rd_six   = 6'(rd_data - CHAR_BASE);
  // The sum character covers every byte received on the line except itself; carried characters are not included.
  assign sum_char = {2'b00, 6'(line_sum - last_byte[5:0])} + CHAR_BASE;
  assign t_now    = six_shift[29:6];
  assign ext_time = {wrap_count, prev_time};
  assign size     = with_intensity ? 3'd6 : 3'd3;
  assign usable   = line_length - LEN_W'(1);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    status.phase        = phase;
    status.is_lf        = (rx_byte == CHAR_LF);
    status.full         = (line_length >= LEN_W'(STORE_DEPTH));
    status.stamp_ok     = (line_length == LEN_W'(5)) && (sum_char == last_byte);
    status.repeat_fail  = (t_now == prev_time) && (repeat_count >= 2'd2);
    status.line_empty   = (line_length == LEN_W'(carry_count));
    status.data_sum_ok  = (sum_char == last_byte);
    status.reading_fits = ({1'b0, rd_ptr} + (LEN_W + 1)'(size)) <= {1'b0, usable};
    status.limit_hit    = (reading_count >= RCNT_W'(READING_LIMIT));
    status.take_last    = (g_cnt == size - 3'd1);
    status.copy_done    = (rd_ptr == usable);
    status.out_free     = out_free;
  end

  // Line memory: one write port, one registered read port.
  always_comb begin
    wr_en   = cmd.store_byte || cmd.copy_write;
    wr_addr = cmd.store_byte ? line_length[ADDR_W-1:0] : ADDR_W'(cp_dst);
    wr_data = cmd.store_byte ? rx_byte : rd_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    rd_data <= line_mem[rd_ptr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      with_intensity <= 1'b0;
    end else if (cfg_we) begin
      with_intensity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_STAMP;
      line_length   <= '0;
      carry_count   <= '0;
      reading_count <= '0;
      line_sum      <= '0;
      prev_time     <= '0;
      wrap_count    <= '0;
      repeat_count  <= '0;
    end else begin
      if (cmd.store_byte) begin
        line_length <= line_length + LEN_W'(1);
        line_sum    <= line_sum + rx_byte[5:0];
      end
      if (cmd.start_scan) begin
        phase         <= PH_STAMP;
        line_length   <= '0;
        carry_count   <= '0;
        reading_count <= '0;
        line_sum      <= '0;
      end
      if (cmd.clock_reset) begin
        prev_time  <= '0;
        wrap_count <= '0;
      end
      if (cmd.repeat_bump) begin
        repeat_count <= 2'd3;
      end
      if (cmd.stamp_commit) begin
        if (t_now == prev_time) begin
          repeat_count <= repeat_count + 2'd1;
        end else begin
          repeat_count <= '0;
        end
        if (t_now < prev_time) begin
          wrap_count <= wrap_count + 32'd1;
        end
        prev_time     <= t_now;
        phase         <= PH_DATA;
        line_length   <= '0;
        carry_count   <= '0;
        reading_count <= '0;
        line_sum      <= '0;
      end
      if (cmd.load_err || cmd.load_end) begin
        phase       <= PH_HALT;
        line_length <= '0;
        carry_count <= '0;
        line_sum    <= '0;
      end
      if (cmd.load_reading) begin
        reading_count <= reading_count + RCNT_W'(1);
      end
      if (cmd.copy_finish) begin
        line_length <= LEN_W'(cp_dst);
        carry_count <= cp_dst;
        line_sum    <= '0;
      end
    end
  end

  // Payload and walk registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      last_byte <= rx_byte;
      six_shift <= {six_shift[23:0], rx_six};
    end
    if (cmd.set_err) begin
      err_r <= cmd.err_code;
    end
    if (cmd.mul_lo) begin
      prod_lo <= 48'(ext_time[27:0]) * 48'(STAMP_SCALE);
    end
    if (cmd.mul_hi) begin
      prod_hi <= 36'(48'(ext_time[55:28]) * 48'(STAMP_SCALE));
    end
    if (cmd.walk_start) begin
      rd_ptr <= '0;
      cp_dst <= '0;
    end
    if (cmd.read_begin) begin
      g_cnt <= '0;
    end
    if (cmd.read_take) begin
      gather <= {gather[29:0], rd_six};
      g_cnt  <= g_cnt + 3'd1;
      rd_ptr <= rd_ptr + LEN_W'(1);
    end
    if (cmd.copy_write) begin
      rd_ptr <= rd_ptr + LEN_W'(1);
      cp_dst <= cp_dst + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_stamp || cmd.load_err || cmd.load_end || cmd.load_reading) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stamp) begin
      kind       <= KIND_STAMP;
      stamp_ns   <= 64'(prod_lo) + {prod_hi, 28'd0};
      range_mm   <= '0;
      strength   <= '0;
      error_code <= ERR_NONE;
      last       <= 1'b1;
    end else if (cmd.load_err) begin
      kind       <= KIND_ERROR;
      stamp_ns   <= '0;
      range_mm   <= '0;
      strength   <= '0;
      error_code <= err_r;
      last       <= 1'b1;
    end else if (cmd.load_end) begin
      kind       <= KIND_END;
      stamp_ns   <= '0;
      range_mm   <= '0;
      strength   <= '0;
      error_code <= ERR_NONE;
      last       <= 1'b1;
    end else if (cmd.load_reading) begin
      kind       <= KIND_READING;
      stamp_ns   <= '0;
      range_mm   <= with_intensity ? gather[35:18] : gather[17:0];
      strength   <= with_intensity ? gather[17:0] : 18'd0;
      error_code <= ERR_NONE;
      // No further reading fits, so nothing follows this one.
      last       <= !status.reading_fits;
    end
  end

endmodule

/* rtl/laser_scan_reply_decoder.sv */
// ----------------------------------------------------------------------------
// laser_scan_reply_decoder
// Decodes six-bit encoded scan reply lines into timestamps and readings.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry action and rx_byte. Output channel:
// out_valid/out_stall carry kind, stamp_ns, range_mm, strength, error_code
// and last; last marks the final result of one input transaction.
// cfg_we/cfg_wdata write with_intensity; the user must write it only while
// the block is idle, which the block does not enforce. An ordinary byte is
// stored without a stall. A timestamp LF forms the low and high partial
// products of the scaling multiply, then loads the output. A data-line LF
// walks the line memory, whose single read port sets the pace: it fetches
// and takes the characters of each reading, then copies carried characters.
// One transaction is worked on at a time; in_stall is high while a line is
// being processed. A finished result sits in the output register, so the
// next byte is taken while it waits. When out_stall is high the result
// holds and the sequencer waits before loading another.
// Reset clears the state to awaiting a timestamp line, the time extension
// to zero and with_intensity to zero; the output register comes up empty.
// ----------------------------------------------------------------------------
module laser_scan_reply_decoder import lsrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [63:0] stamp_ns,
  output logic [17:0] range_mm,
  output logic [17:0] strength,
  output logic [2:0]  error_code,
  output logic        last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lsrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  lsrd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .status     (status),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .kind       (kind),
    .stamp_ns   (stamp_ns),
    .range_mm   (range_mm),
    .strength   (strength),
    .error_code (error_code),
    .last       (last)
  );

endmodule

/* rtl/lsrd_chk.sv */
// ----------------------------------------------------------------------------
// lsrd_chk
// Port-level checks of the output channel of the scan reply decoder.
// ----------------------------------------------------------------------------
module lsrd_chk import lsrd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [63:0] stamp_ns,
  input logic [2:0]  error_code,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(stamp_ns)
      && $stable(error_code) && $stable(last))
    else $error("stalled output transaction changed");

  a_stamp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_STAMP) |-> (stamp_ns == 64'd0))
    else $error("stamp field set on a non-timestamp result");

  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((kind == KIND_END) || (kind == KIND_ERROR)) |-> last)
    else $error("end of scan or error not marked last");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_ERROR) |-> (error_code == ERR_NONE))
    else $error("error code set on a non-error result");

endmodule

bind laser_scan_reply_decoder lsrd_chk u_lsrd_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .stamp_ns   (stamp_ns),
  .error_code (error_code),
  .last       (last)
);

/* test/laser_scan_reply_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_reply_decoder_test
// Drives scan replies (timestamp lines, data lines, empty end lines, noise and
// broken lines) into the decoder under random idling on both channels, and
// checks every result field against a behavioral predictor of the decoder.
// ----------------------------------------------------------------------------
import lsrd_pkg::*;

typedef struct packed {
  logic [1:0]  kind;
  logic [63:0] stamp_ns;
  logic [17:0] range_mm;
  logic [17:0] strength;
  logic [2:0]  error_code;
  logic        last;
} scan_result_t;

class scan_scoreboard;
  phase_t      phase;
  logic [7:0]  line_mem [STORE_DEPTH];
  int unsigned line_len;
  int unsigned carry_len;
  int unsigned reading_cnt;
  logic [23:0] prev_time;
  logic [31:0] wraps;
  int unsigned repeats;
  bit          intensity_mode;
  scan_result_t pending [$];
  int unsigned  errors;

  function new();
    phase = PH_STAMP;
    line_len = 0;
    carry_len = 0;
    reading_cnt = 0;
    prev_time = '0;
    wraps = '0;
    repeats = 0;
    intensity_mode = 0;
    errors = 0;
  endfunction

  function logic [5:0] sixbit(logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_BASE;
    return d[5:0];
  endfunction

  function logic [17:0] triple(int unsigned at);
    return {sixbit(line_mem[at]), sixbit(line_mem[at+1]), sixbit(line_mem[at+2])};
  endfunction

  function void push(logic [1:0] k, logic [63:0] st, logic [17:0] r, logic [17:0] s,
                     logic [2:0] e);
    scan_result_t x;
    x.kind = k;
    x.stamp_ns = st;
    x.range_mm = r;
    x.strength = s;
    x.error_code = e;
    x.last = 0;
    pending = {pending, x};
  endfunction

  function void halt_with(logic [2:0] e);
    push(KIND_ERROR, '0, '0, '0, e);
    phase = PH_HALT;
    line_len = 0;
    carry_len = 0;
  endfunction

  function void finish_stamp();
    logic [7:0]  sum;
    logic [23:0] t;
    logic [63:0] ext;
    if (line_len != 5) begin
      halt_with(ERR_STAMP_SUM);
      return;
    end
    sum = line_mem[0] + line_mem[1] + line_mem[2] + line_mem[3];
    if ({2'b0, sum[5:0]} + CHAR_BASE != line_mem[4]) begin
      halt_with(ERR_STAMP_SUM);
      return;
    end
    t = {sixbit(line_mem[0]), sixbit(line_mem[1]), sixbit(line_mem[2]), sixbit(line_mem[3])};
    if (t == prev_time) begin
      if (repeats < 3) repeats++;
      if (repeats > 2) begin
        halt_with(ERR_REPEAT);
        return;
      end
    end else begin
      repeats = 0;
    end
    if (t < prev_time) wraps++;
    prev_time = t;
    ext = {8'b0, wraps, t};
    push(KIND_STAMP, ext * 64'd1000000, '0, '0, ERR_NONE);
    phase = PH_DATA;
    line_len = 0;
    carry_len = 0;
    reading_cnt = 0;
  endfunction

  function void finish_data();
    logic [7:0]  sum;
    int unsigned size, usable, whole;
    logic [17:0] s;
    if (line_len == carry_len) begin
      push(KIND_END, '0, '0, '0, ERR_NONE);
      phase = PH_HALT;
      line_len = 0;
      carry_len = 0;
      return;
    end
    sum = 0;
    for (int unsigned i = carry_len; i + 1 < line_len; i++) sum += line_mem[i];
    if ({2'b0, sum[5:0]} + CHAR_BASE != line_mem[line_len-1]) begin
      halt_with(ERR_DATA_SUM);
      return;
    end
    size = intensity_mode ? 6 : 3;
    usable = line_len - 1;
    whole = usable - usable % size;
    for (int unsigned j = 0; j < whole; j += size) begin
      if (reading_cnt >= READING_LIMIT) begin
        halt_with(ERR_TOO_MANY);
        return;
      end
      s = intensity_mode ? triple(j + 3) : '0;
      push(KIND_READING, '0, triple(j), s, ERR_NONE);
      reading_cnt++;
    end
    carry_len = usable - whole;
    for (int unsigned i = 0; i < carry_len; i++) line_mem[i] = line_mem[whole + i];
    line_len = carry_len;
  endfunction

  // Notes one accepted input transaction and queues what it should produce.
  function void note_input(logic [1:0] act, logic [7:0] b);
    int unsigned prior_size;
    prior_size = pending.size();
    if (act == ACT_START) begin
      phase = PH_STAMP;
      line_len = 0;
      carry_len = 0;
      reading_cnt = 0;
      return;
    end
    if (act == ACT_CLK_RESET) begin
      prev_time = '0;
      wraps = '0;
      return;
    end
    if (act != ACT_BYTE || phase == PH_HALT) return;
    if (b != CHAR_LF) begin
      if (line_len >= STORE_DEPTH) halt_with(ERR_OVERFLOW);
      else line_mem[line_len++] = b;
    end else if (phase == PH_STAMP) begin
      finish_stamp();
    end else begin
      finish_data();
    end
    if (pending.size() > prior_size) pending[pending.size()-1].last = 1;
  endfunction

  function void check_result(scan_result_t got);
    scan_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.kind != want.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
      errors++;
    end
    if (got.stamp_ns != want.stamp_ns) begin
      $display("%0t: stamp_ns expected %0d actual %0d", $time, want.stamp_ns, got.stamp_ns);
      errors++;
    end
    if (got.range_mm != want.range_mm) begin
      $display("%0t: range_mm expected %0d actual %0d", $time, want.range_mm, got.range_mm);
      errors++;
    end
    if (got.strength != want.strength) begin
      $display("%0t: strength expected %0d actual %0d", $time, want.strength, got.strength);
      errors++;
    end
    if (got.error_code != want.error_code) begin
      $display("%0t: error_code expected %0d actual %0d", $time, want.error_code,
               got.error_code);
      errors++;
    end
    if (got.last != want.last) begin
      $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module laser_scan_reply_decoder_test;
  localparam int QUIET_LIMIT = 20000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  action = ACT_BYTE;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  kind;
  logic [63:0] stamp_ns;
  logic [17:0] range_mm;
  logic [17:0] strength;
  logic [2:0]  error_code;
  logic        last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_items = 0;
  logic [23:0] next_time = 24'd100;

  scan_scoreboard board = new();

  laser_scan_reply_decoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .stamp_ns(stamp_ns),
    .range_mm(range_mm), .strength(strength), .error_code(error_code), .last(last)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Receiver side: random stall, plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result({kind, stamp_ns, range_mm, strength, error_code, last});
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL laser_scan_reply_decoder");
      $finish;
    end
  end

  // Valid stays high after an accepted transaction so that a following one
  // can go out back to back; whoever waits afterwards drops it.
  task automatic send(logic [1:0] act, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    board.note_input(act, b);
    sent_items++;
  endtask

  function automatic logic [7:0] encode(logic [5:0] v);
    return {2'b0, v} + CHAR_BASE;
  endfunction

  // Sends chars then their sum character and LF.
  task automatic send_line(logic [7:0] chars [$]);
    logic [7:0] sum;
    sum = 0;
    foreach (chars[i]) begin
      send(ACT_BYTE, chars[i]);
      sum += chars[i];
    end
    send(ACT_BYTE, encode(sum[5:0]));
    send(ACT_BYTE, CHAR_LF);
  endtask

  task automatic send_stamp(logic [23:0] t);
    logic [7:0] q [$];
    q = {encode(t[23:18]), encode(t[17:12]), encode(t[11:6]), encode(t[5:0])};
    send_line(q);
  endtask

  task automatic send_data(int unsigned n, bit wild);
    logic [7:0] q [$];
    for (int unsigned i = 0; i < n; i++)
      q = {q, (wild ? 8'($urandom_range(255)) : encode(6'($urandom_range(63))))};
    // LF inside a data line would split it; keep it out of the content.
    foreach (q[i]) if (q[i] == CHAR_LF) q[i] = 8'h0B;
    send_line(q);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_intensity(bit v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    board.intensity_mode = v;
    cfg_we <= 0;
  endtask

  task automatic random_scan();
    int unsigned r;
    r = $urandom_range(99);
    send(ACT_START, 8'($urandom_range(255)));
    if (r < 5) send(ACT_CLK_RESET, 8'($urandom_range(255)));
    if (r < 8) begin
      send_stamp(next_time);
    end else if (r < 12) begin
      send(ACT_BYTE, 8'($urandom_range(255)));
      send(ACT_BYTE, CHAR_LF);
    end else begin
      next_time = ($urandom_range(9) == 0) ? 24'($urandom) : next_time + 24'($urandom_range(50));
      send_stamp(next_time);
    end
    repeat ($urandom_range(3)) begin
      r = $urandom_range(99);
      if (r < 6) send_data($urandom_range(62), 1);
      else if (r < 9) send(ACT_BYTE, 8'($urandom_range(255)));
      else if (r < 11) send(ACT_BYTE, CHAR_LF);
      else if (r < 13) send(ACT_UNUSED, 8'($urandom_range(255)));
      else send_data($urandom_range(1, 20), 0);
    end
    send(ACT_BYTE, CHAR_LF);
  endtask

  initial begin
    logic [7:0] q [$];
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extreme times, wrap, repeats, sums, carries, overflow.
    send_stamp(24'hFFFFFF);
    send_data(5, 0);
    send_data(4, 0);
    send(ACT_BYTE, CHAR_LF);
    send(ACT_START, 8'hFF);
    send_stamp(24'h000000);
    send(ACT_BYTE, 8'h00);
    send(ACT_BYTE, 8'hFF);
    send(ACT_BYTE, 8'h30);
    send(ACT_BYTE, CHAR_LF);
    send(ACT_UNUSED, 8'hAA);
    send(ACT_START, 8'h00);
    send_stamp(24'h000000);
    send(ACT_START, 8'h00);
    send_stamp(24'h000000);
    send(ACT_CLK_RESET, 8'h55);
    send(ACT_START, 8'h00);
    send(ACT_BYTE, 8'h30);
    send(ACT_BYTE, CHAR_LF);
    send(ACT_START, 8'h00);
    send_stamp(24'h000123);
    send_data(70, 0);
    send(ACT_START, 8'h00);
    q = {8'h30, 8'h30, 8'h30, 8'h30, 8'h31};
    foreach (q[i]) send(ACT_BYTE, q[i]);
    send(ACT_BYTE, CHAR_LF);

    set_intensity(1);
    send(ACT_START, 8'h00);
    send_stamp(24'h000200);
    send_data(20, 1);
    send(ACT_BYTE, CHAR_LF);

    // Several lines in one scan; each holds whole readings, so none carries characters.
    set_intensity(0);
    send(ACT_START, 8'h00);
    send_stamp(24'h000300);
    send_clk_free: for (int i = 0; i < 2; i++) send_data(30, 0);
    send(ACT_BYTE, CHAR_LF);

    // Long receiver hold-off while bytes keep coming.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        send(ACT_START, 8'h00);
        send_stamp(24'h000400);
        repeat (3) send_data(10, 0);
        in_valid <= 0;
        @(posedge clk);
      end
    join

    send_idle_pct = 10;
    recv_idle_pct = 85;
    while (sent_items < 340) random_scan();
    set_intensity(1);
    send_idle_pct = 85;
    recv_idle_pct = 10;
    while (sent_items < 395) random_scan();
    set_intensity(0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent_items < 450) random_scan();

    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS laser_scan_reply_decoder");
    else
      $display("FAIL laser_scan_reply_decoder");
    $finish;
  end
endmodule

/* filelist.f */
rtl/lsrd_pkg.sv
rtl/lsrd_ctrl.sv
rtl/lsrd_dp.sv
rtl/laser_scan_reply_decoder.sv
rtl/lsrd_chk.sv
test/laser_scan_reply_decoder_test.sv
